// ----- design/plp_pkg.sv -----
// shared types, constants and lookup functions for the polyline record parser
package plp_pkg;

    // fixed formats of the stream
    localparam int MANT_W = 24;
    localparam int SCALE_W = 32;
    localparam int PROD_W = MANT_W + SCALE_W;
    localparam int EXP_W = 7;

    // default module parameters
    localparam int COORD_WIDTH_DEF = 40;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [31:0] MAGIC_VALUE = 32'd1234500;
    // 25.4 in unsigned Q16.16
    localparam logic [SCALE_W-1:0] UNIT_SCALE_RESET = 32'd1664614;
    localparam logic [15:0] PATTERN_SOLID = 16'hFFFF;

    // result kinds
    localparam logic [1:0] RK_SEGMENT = 2'd0;
    localparam logic [1:0] RK_BAD_MAGIC = 2'd1;
    localparam logic [1:0] RK_BOUNDS_CLEAN = 2'd2;
    localparam logic [1:0] RK_BOUNDS_EARLY = 2'd3;

    // operations handed from the parser into the coordinate pipeline
    typedef enum logic [2:0] {
        OP_X         = 3'd0,
        OP_Y         = 3'd1,
        OP_BAD       = 3'd2,
        OP_END_CLEAN = 3'd3,
        OP_END_EARLY = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        emit;
        logic [3:0]  color;
        logic [15:0] pattern;
        logic [7:0]  layer;
        logic        thick;
    } t_op_ctl;

    // pen color translation of the color nibble
    function automatic logic [3:0] color_lookup(input logic [3:0] nib);
        logic [3:0] res;
        case (nib)
            4'd0:    res = 4'd0;
            4'd1:    res = 4'd1;
            4'd2:    res = 4'd2;
            4'd3:    res = 4'd3;
            4'd4:    res = 4'd6;
            4'd5:    res = 4'd7;
            4'd6:    res = 4'd8;
            4'd7:    res = 4'd9;
            4'd8:    res = 4'd10;
            4'd9:    res = 4'd11;
            4'd10:   res = 4'd12;
            4'd11:   res = 4'd13;
            4'd12:   res = 4'd14;
            4'd13:   res = 4'd15;
            4'd14:   res = 4'd6;
            default: res = 4'd7;
        endcase
        return res;
    endfunction

    // dash pattern of a line type, solid for type 0 and above the known types
    function automatic logic [15:0] pattern_lookup(input logic [7:0] ltype);
        logic [15:0] res;
        case (ltype)
            8'd1:    res = 16'hCCCC;
            8'd2:    res = 16'hFF00;
            8'd3:    res = 16'hFFF0;
            8'd4:    res = 16'hFFCC;
            8'd5:    res = 16'hCC3C;
            8'd6:    res = 16'hFCCC;
            default: res = PATTERN_SOLID;
        endcase
        return res;
    endfunction

endpackage

// ----- design/plp_parser.sv -----
// byte-level stream parser: magic check, record headers and coordinate word assembly
module plp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_kind,
    input  logic [7:0]         i_data_byte,
    output logic               o_op_valid,
    output plp_pkg::t_op_ctl   o_op_ctl,
    output logic [31:0]        o_op_word
);

    typedef enum logic [3:0] {
        PH_MAGIC  = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_POINTS = 4'b0100,
        PH_DEAD   = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bpos, n_bpos;
    logic [7:0]  r_points, n_points;
    logic [3:0]  r_color, n_color;
    logic [15:0] r_pattern, n_pattern;
    logic [7:0]  r_layer, n_layer;
    logic        r_thick, n_thick;
    logic [31:0] r_word, n_word;
    logic        r_have_prev, n_have_prev;
    logic [31:0] shifted_word;
    logic [7:0]  points_dec;

    assign shifted_word = {r_word[23:0], i_data_byte};
    assign points_dec = r_points - 8'd1;
    assign o_op_word = shifted_word;

    // next parse state and the operation this byte starts
    always_comb begin
        n_phase = r_phase;
        n_bpos = r_bpos;
        n_points = r_points;
        n_color = r_color;
        n_pattern = r_pattern;
        n_layer = r_layer;
        n_thick = r_thick;
        n_word = r_word;
        n_have_prev = r_have_prev;
        o_op_valid = 1'b0;
        o_op_ctl.op = plp_pkg::OP_X;
        o_op_ctl.emit = r_have_prev;
        o_op_ctl.color = r_color;
        o_op_ctl.pattern = r_pattern;
        o_op_ctl.layer = r_layer;
        o_op_ctl.thick = r_thick;
        if (i_accept) begin
            if (i_kind) begin
                // end of input: report the box unless the stream was rejected
                if (r_phase != PH_DEAD) begin
                    o_op_valid = 1'b1;
                    o_op_ctl.op = (r_phase == PH_HEADER && r_bpos == 3'd0) ?
                                  plp_pkg::OP_END_CLEAN : plp_pkg::OP_END_EARLY;
                end
                n_phase = PH_MAGIC;
                n_bpos = 3'd0;
                n_points = 8'd0;
                n_color = 4'd0;
                n_pattern = plp_pkg::PATTERN_SOLID;
                n_layer = 8'd0;
                n_thick = 1'b0;
                n_word = 32'd0;
                n_have_prev = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_MAGIC: begin
                        if (r_bpos == 3'd3) begin
                            n_bpos = 3'd0;
                            n_word = 32'd0;
                            if (shifted_word == plp_pkg::MAGIC_VALUE) begin
                                n_phase = PH_HEADER;
                            end else begin
                                n_phase = PH_DEAD;
                                o_op_valid = 1'b1;
                                o_op_ctl.op = plp_pkg::OP_BAD;
                            end
                        end else begin
                            n_bpos = r_bpos + 3'd1;
                            n_word = shifted_word;
                        end
                    end
                    PH_HEADER: begin
                        case (r_bpos)
                            3'd0:    n_points = i_data_byte;
                            3'd1:    n_color = plp_pkg::color_lookup(i_data_byte[3:0]);
                            3'd2:    n_pattern = plp_pkg::pattern_lookup(i_data_byte);
                            3'd3:    ;
                            3'd4:    n_thick = i_data_byte[0];
                            default: n_layer = i_data_byte;
                        endcase
                        if (r_bpos >= 3'd5) begin
                            n_bpos = 3'd0;
                            n_have_prev = 1'b0;
                            if (r_points != 8'd0) begin
                                n_phase = PH_POINTS;
                            end
                        end else begin
                            n_bpos = r_bpos + 3'd1;
                        end
                    end
                    PH_POINTS: begin
                        if (r_bpos == 3'd3) begin
                            o_op_valid = 1'b1;
                            o_op_ctl.op = plp_pkg::OP_X;
                            n_word = 32'd0;
                            n_bpos = r_bpos + 3'd1;
                        end else if (r_bpos == 3'd7) begin
                            o_op_valid = 1'b1;
                            o_op_ctl.op = plp_pkg::OP_Y;
                            n_word = 32'd0;
                            n_bpos = 3'd0;
                            n_have_prev = 1'b1;
                            n_points = points_dec;
                            if (points_dec == 8'd0) begin
                                n_phase = PH_HEADER;
                            end
                        end else begin
                            n_word = shifted_word;
                            n_bpos = r_bpos + 3'd1;
                        end
                    end
                    PH_DEAD: ;
                    default: ;
                endcase
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_bpos <= 3'd0;
            r_points <= 8'd0;
            r_color <= 4'd0;
            r_pattern <= plp_pkg::PATTERN_SOLID;
            r_layer <= 8'd0;
            r_thick <= 1'b0;
            r_word <= 32'd0;
            r_have_prev <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bpos <= n_bpos;
            r_points <= n_points;
            r_color <= n_color;
            r_pattern <= n_pattern;
            r_layer <= n_layer;
            r_thick <= n_thick;
            r_word <= n_word;
            r_have_prev <= n_have_prev;
        end
    end

    // a rejected stream starts no coordinate work
    a_dead_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DEAD && i_accept && !i_kind) |-> !o_op_valid)
        else $error("parser issued an operation after a bad magic");

endmodule

// ----- design/plp_ffp_sat.sv -----
// scaled ffp product to signed fixed point: exponent shift, saturation and sign
module plp_ffp_sat #(
    parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = plp_pkg::FRACTION_BITS_DEF
) (
    input  logic [plp_pkg::PROD_W-1:0]  i_prod,
    input  logic [plp_pkg::EXP_W-1:0]   i_exp,
    input  logic                        i_neg,
    output logic signed [COORD_WIDTH-1:0] o_coord
);

    // shift = exponent - 64 - 40 + fraction bits
    localparam int SHIFT_BIAS = 104 - FRACTION_BITS;
    localparam int MAX_LSH = 127 - SHIFT_BIAS;
    localparam int WIDE_W = plp_pkg::PROD_W + MAX_LSH;
    localparam logic [WIDE_W-1:0] LIM_NEG = {{(WIDE_W-COORD_WIDTH){1'b0}}, 1'b1,
                                             {(COORD_WIDTH-1){1'b0}}};
    localparam logic [WIDE_W-1:0] LIM_POS = LIM_NEG - {{(WIDE_W-1){1'b0}}, 1'b1};

    logic signed [8:0]       shift;
    logic [6:0]              lsh;
    logic [6:0]              rsh;
    logic [WIDE_W-1:0]       prod_ext;
    logic [WIDE_W-1:0]       wide;
    logic [WIDE_W-1:0]       lim;
    logic [WIDE_W-1:0]       mag_wide;
    logic [COORD_WIDTH-1:0]  mag;

    assign shift = $signed({2'b00, i_exp}) - 9'(SHIFT_BIAS);
    assign lsh = shift[8] ? 7'd0 : shift[6:0];
    assign rsh = shift[8] ? 7'(-shift) : 7'd0;
    assign prod_ext = {{(WIDE_W-plp_pkg::PROD_W){1'b0}}, i_prod};

    // scale by the exponent, truncating toward zero
    always_comb begin
        if (shift[8]) begin
            wide = prod_ext >> rsh;
        end else begin
            wide = prod_ext << lsh;
        end
    end

    // clamp the magnitude, then apply the sign
    assign lim = i_neg ? LIM_NEG : LIM_POS;
    assign mag_wide = (wide > lim) ? lim : wide;
    assign mag = mag_wide[COORD_WIDTH-1:0];
    assign o_coord = i_neg ? $signed(-mag) : $signed(mag);

endmodule

// ----- design/polyline_record_parser.sv -----
// top level of the polyline record parser: handshakes, coordinate pipeline, bounds
//
// Input channel: one transaction per stream byte (i_kind 0) or end of input (i_kind 1),
// taken when i_in_valid and o_in_ready are both high; bytes go one per cycle while ready.
// Output channel: a result register drives o_out_valid and the result fields; a
// transaction completes when o_out_valid and i_out_ready are both high.
// Config channel: i_cfg_valid writes i_cfg_unit_scale; o_cfg_ready is always high.
// The scale is sampled when a coordinate word enters the multiplier.
// Pipeline: the operation a byte causes passes the operation register, the 24x32
// mantissa-by-scale multiplier register and the shift/saturate register, then the
// result register. Throughput: one input transaction per cycle while o_in_ready is
// high, set by the parser's byte-per-cycle state update; coordinate words go through
// the multiplier once per 4 bytes.
// When the receiver stalls, the pipeline keeps filling its three internal slots
// and o_in_ready drops only when every slot and the result register are full.
// Reset (synchronous, active low) empties the pipeline, restores the unit scale to
// 25.4 and returns the parser to expect the magic number; end of input returns the
// parser there too and clears the bounding box, but leaves the unit scale as it is.
module polyline_record_parser #(
    parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = plp_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [7:0]                    i_data_byte,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_result_kind,
    output logic signed [COORD_WIDTH-1:0] o_first_x,
    output logic signed [COORD_WIDTH-1:0] o_first_y,
    output logic signed [COORD_WIDTH-1:0] o_second_x,
    output logic signed [COORD_WIDTH-1:0] o_second_y,
    output logic [3:0]                    o_pen_color,
    output logic [15:0]                   o_dash_pattern,
    output logic [7:0]                    o_layer,
    output logic                          o_thick,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [plp_pkg::SCALE_W-1:0]   i_cfg_unit_scale
);

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam int PAD_W = plp_pkg::PROD_W - plp_pkg::MANT_W;
    localparam int SPAD_W = plp_pkg::PROD_W - plp_pkg::SCALE_W;

    logic                          in_accept;
    logic                          op_valid;
    plp_pkg::t_op_ctl              op_ctl;
    logic [31:0]                   op_word;

    logic [plp_pkg::SCALE_W-1:0]   r_unit_scale;

    // pipeline slots
    logic                          r1_valid, r2_valid, r3_valid;
    plp_pkg::t_op_ctl              r1_ctl, r2_ctl, r3_ctl;
    logic [31:0]                   r1_word;
    logic [plp_pkg::PROD_W-1:0]    r2_prod;
    logic [plp_pkg::EXP_W-1:0]     r2_exp;
    logic                          r2_neg;
    logic signed [COORD_WIDTH-1:0] r3_coord;
    logic signed [COORD_WIDTH-1:0] n3_coord;
    logic [plp_pkg::PROD_W-1:0]    mant_ext, scale_ext, n2_prod;
    logic                          adv1, adv2, adv3;
    logic                          s1_free, s2_free, s3_free;
    logic                          has_result3;

    // point state and bounding box
    logic signed [COORD_WIDTH-1:0] r_pend_x, r_prev_x, r_prev_y;
    logic signed [COORD_WIDTH-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic signed [COORD_WIDTH-1:0] n_min_x, n_min_y, n_max_x, n_max_y;

    // result register
    logic                          r_out_valid;
    logic [1:0]                    r_out_kind, n_out_kind;
    logic signed [COORD_WIDTH-1:0] r_out_ax, r_out_ay, r_out_bx, r_out_by;
    logic signed [COORD_WIDTH-1:0] n_out_ax, n_out_ay, n_out_bx, n_out_by;
    logic [3:0]                    r_out_color, n_out_color;
    logic [15:0]                   r_out_pattern, n_out_pattern;
    logic [7:0]                    r_out_layer, n_out_layer;
    logic                          r_out_thick, n_out_thick;

    // stall chain from the result register back to the input
    always_comb begin
        case (r3_ctl.op) inside
            plp_pkg::OP_Y: has_result3 = r3_ctl.emit;
            plp_pkg::OP_BAD, plp_pkg::OP_END_CLEAN, plp_pkg::OP_END_EARLY: has_result3 = 1'b1;
            default: has_result3 = 1'b0;
        endcase
    end

    assign adv3 = r3_valid && (!has_result3 || !r_out_valid || i_out_ready);
    assign s3_free = !r3_valid || adv3;
    assign adv2 = r2_valid && s3_free;
    assign s2_free = !r2_valid || adv2;
    assign adv1 = r1_valid && s2_free;
    assign s1_free = !r1_valid || adv1;

    assign o_in_ready = s1_free;
    assign in_accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    plp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_op_valid  (op_valid),
        .o_op_ctl    (op_ctl),
        .o_op_word   (op_word)
    );

    // mantissa times unit scale
    assign mant_ext = {{PAD_W{1'b0}}, r1_word[31:8]};
    assign scale_ext = {{SPAD_W{1'b0}}, r_unit_scale};
    assign n2_prod = mant_ext * scale_ext;

    plp_ffp_sat #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ffp_sat (
        .i_prod  (r2_prod),
        .i_exp   (r2_exp),
        .i_neg   (r2_neg),
        .o_coord (n3_coord)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_scale <= plp_pkg::UNIT_SCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_unit_scale <= i_cfg_unit_scale;
        end
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= (in_accept && op_valid) || (r1_valid && !adv1);
            r2_valid <= adv1 || (r2_valid && !adv2);
            r3_valid <= adv2 || (r3_valid && !adv3);
        end
    end

    // slot payloads
    always_ff @(posedge i_clk) begin
        if (in_accept && op_valid) begin
            r1_ctl <= op_ctl;
            r1_word <= op_word;
        end
        if (adv1) begin
            r2_ctl <= r1_ctl;
            r2_prod <= n2_prod;
            r2_exp <= r1_word[6:0];
            r2_neg <= r1_word[7];
        end
        if (adv2) begin
            r3_ctl <= r2_ctl;
            r3_coord <= n3_coord;
        end
    end

    // bounding box with the new point folded in
    always_comb begin
        n_min_x = (r_pend_x < r_min_x) ? r_pend_x : r_min_x;
        n_max_x = (r_pend_x > r_max_x) ? r_pend_x : r_max_x;
        n_min_y = (r3_coord < r_min_y) ? r3_coord : r_min_y;
        n_max_y = (r3_coord > r_max_y) ? r3_coord : r_max_y;
    end

    // result formation
    always_comb begin
        n_out_kind = plp_pkg::RK_SEGMENT;
        n_out_ax = '0;
        n_out_ay = '0;
        n_out_bx = '0;
        n_out_by = '0;
        n_out_color = 4'd0;
        n_out_pattern = 16'd0;
        n_out_layer = 8'd0;
        n_out_thick = 1'b0;
        case (r3_ctl.op) inside
            plp_pkg::OP_Y: begin
                n_out_ax = r_prev_x;
                n_out_ay = r_prev_y;
                n_out_bx = r_pend_x;
                n_out_by = r3_coord;
                n_out_color = r3_ctl.color;
                n_out_pattern = r3_ctl.pattern;
                n_out_layer = r3_ctl.layer;
                n_out_thick = r3_ctl.thick;
            end
            plp_pkg::OP_BAD: n_out_kind = plp_pkg::RK_BAD_MAGIC;
            plp_pkg::OP_END_CLEAN, plp_pkg::OP_END_EARLY: begin
                n_out_kind = (r3_ctl.op == plp_pkg::OP_END_CLEAN) ?
                             plp_pkg::RK_BOUNDS_CLEAN : plp_pkg::RK_BOUNDS_EARLY;
                n_out_ax = r_min_x;
                n_out_ay = r_min_y;
                n_out_bx = r_max_x;
                n_out_by = r_max_y;
            end
            default: ;
        endcase
    end

    // bounds and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_min_x <= COORD_MAX;
            r_min_y <= COORD_MAX;
            r_max_x <= COORD_MIN;
            r_max_y <= COORD_MIN;
        end else begin
            if (adv3 && has_result3) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv3) begin
                case (r3_ctl.op) inside
                    plp_pkg::OP_Y: begin
                        r_min_x <= n_min_x;
                        r_min_y <= n_min_y;
                        r_max_x <= n_max_x;
                        r_max_y <= n_max_y;
                    end
                    plp_pkg::OP_END_CLEAN, plp_pkg::OP_END_EARLY: begin
                        r_min_x <= COORD_MAX;
                        r_min_y <= COORD_MAX;
                        r_max_x <= COORD_MIN;
                        r_max_y <= COORD_MIN;
                    end
                    default: ;
                endcase
            end
        end
    end

    // point history and result payload
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            if (r3_ctl.op == plp_pkg::OP_X) begin
                r_pend_x <= r3_coord;
            end
            if (r3_ctl.op == plp_pkg::OP_Y) begin
                r_prev_x <= r_pend_x;
                r_prev_y <= r3_coord;
            end
        end
        if (adv3 && has_result3) begin
            r_out_kind <= n_out_kind;
            r_out_ax <= n_out_ax;
            r_out_ay <= n_out_ay;
            r_out_bx <= n_out_bx;
            r_out_by <= n_out_by;
            r_out_color <= n_out_color;
            r_out_pattern <= n_out_pattern;
            r_out_layer <= n_out_layer;
            r_out_thick <= n_out_thick;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_first_x = r_out_ax;
    assign o_first_y = r_out_ay;
    assign o_second_x = r_out_bx;
    assign o_second_y = r_out_by;
    assign o_pen_color = r_out_color;
    assign o_dash_pattern = r_out_pattern;
    assign o_layer = r_out_layer;
    assign o_thick = r_out_thick;

    // input stalls only with every slot and the result register occupied
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r1_valid && r2_valid && r3_valid && r_out_valid && !i_out_ready))
        else $error("input stalled while the pipeline had room");

    // a recorded point leaves a non-empty box
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv3 && r3_ctl.op == plp_pkg::OP_Y) |=> (r_min_x <= r_max_x && r_min_y <= r_max_y))
        else $error("bounding box inverted after a point");

    // end of input clears the box
    a_box_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv3 && (r3_ctl.op == plp_pkg::OP_END_CLEAN || r3_ctl.op == plp_pkg::OP_END_EARLY))
        |=> (r_min_x == COORD_MAX && r_max_y == COORD_MIN))
        else $error("bounding box not cleared at end of input");

endmodule
